// File: rtl/fwoh_pkg.sv
// Shared types and constants for the word FIFO with overflow halt.
// No dependencies; used by fwoh_core, fwoh_skid and fifo_with_overflow_halt.
package fwoh_pkg;

    localparam int MAX_VISIBLE_DEF = 32;
    localparam int SPILL_DEPTH_DEF = 32;
    localparam logic [5:0] DEPTH_RESET = 6'd32;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_PEEK  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    // packed so that read_word sits in the low bits
    typedef struct packed {
        logic [5:0]  peak_spill;
        logic [6:0]  fill_level;
        logic        push_dropped;
        logic        dest_release;
        logic        dest_halt;
        logic        empty_retry;
        logic        source_release;
        logic        source_halt;
        logic [31:0] read_word;
    } result_t;

endpackage

// File: rtl/fwoh_core.sv
// Request engine: ring store, pointers, halt flags, result register.
// Depends on fwoh_pkg.
module fwoh_core #(
    parameter int MAX_VISIBLE = fwoh_pkg::MAX_VISIBLE_DEF,
    parameter int SPILL_DEPTH = fwoh_pkg::SPILL_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  fwoh_pkg::req_t   in_req,
    input  logic [31:0]      in_word,
    input  logic [5:0]       in_offset,
    input  logic             cfg_valid,
    input  logic [5:0]       cfg_data,
    output logic             res_valid,
    input  logic             res_ready,
    output fwoh_pkg::result_t res
);

    localparam int RING = MAX_VISIBLE + SPILL_DEPTH;
    localparam int AW   = $clog2(RING);
    localparam int CW   = $clog2(RING + 1);
    localparam int PKW  = $clog2(SPILL_DEPTH + 1);

    logic [31:0]   ring_mem [RING];

    logic [AW-1:0]  head_reg, head_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           src_halt_reg, src_halt_next;
    logic           dst_halt_reg, dst_halt_next;
    logic [PKW-1:0] peak_reg, peak_next;
    logic [5:0]     depth_reg;
    logic           res_valid_reg;
    fwoh_pkg::result_t res_reg, res_next;
    logic [31:0]    rd_word_reg;

    logic [CW-1:0]  depth_eff;
    logic [CW-1:0]  spill;
    logic           wr_en, rd_en;
    logic [AW-1:0]  wr_addr, rd_addr;
    logic           accept;

    // (head + off) mod RING; head is below RING and off is at most RING
    function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] head,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(off);
        if (sum >= (CW+1)'(RING)) sum = sum - (CW+1)'(RING);
        return sum[AW-1:0];
    endfunction

    assign in_ready  = !res_valid_reg || res_ready;
    assign accept    = in_valid && in_ready;
    assign res_valid = res_valid_reg;

    // flags from the result register, read word from the registered ring read
    always_comb begin
        res           = res_reg;
        res.read_word = rd_word_reg;
    end

    // zero acts as one, anything above the visible limit is clamped
    always_comb begin
        if (depth_reg == 6'd0) begin
            depth_eff = CW'(1);
        end else if (32'(depth_reg) > 32'(MAX_VISIBLE)) begin
            depth_eff = CW'(MAX_VISIBLE);
        end else begin
            depth_eff = CW'(depth_reg);
        end
    end

    assign spill = count_reg + CW'(1) - depth_eff;

    always_comb begin
        res_next      = '0;
        head_next     = head_reg;
        count_next    = count_reg;
        src_halt_next = src_halt_reg;
        dst_halt_next = dst_halt_reg;
        peak_next     = peak_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        wr_addr       = ring_pos(head_reg, count_reg);
        rd_addr       = ring_pos(head_reg, '0);
        unique case (in_req)
            fwoh_pkg::REQ_PUSH: begin
                if (count_reg >= depth_eff) begin
                    if (32'(count_reg) >= 32'(depth_eff) + 32'(SPILL_DEPTH)) begin
                        res_next.push_dropped = 1'b1;
                    end else begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (32'(spill) > 32'(peak_reg)) peak_next = PKW'(spill);
                        if (!src_halt_reg) begin
                            src_halt_next        = 1'b1;
                            res_next.source_halt = 1'b1;
                        end
                    end
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    if (dst_halt_reg) begin
                        dst_halt_next         = 1'b0;
                        res_next.dest_release = 1'b1;
                    end
                end
            end
            fwoh_pkg::REQ_POP: begin
                if (count_reg == '0) begin
                    res_next.empty_retry = 1'b1;
                    if (!dst_halt_reg) begin
                        dst_halt_next      = 1'b1;
                        res_next.dest_halt = 1'b1;
                    end
                end else begin
                    rd_en      = 1'b1;
                    head_next  = ring_pos(head_reg, CW'(1));
                    count_next = count_reg - CW'(1);
                    if (count_reg > depth_eff && count_next <= depth_eff
                        && src_halt_reg) begin
                        src_halt_next           = 1'b0;
                        res_next.source_release = 1'b1;
                    end
                end
            end
            fwoh_pkg::REQ_PEEK: begin
                if (32'(in_offset) < 32'(count_reg)) begin
                    rd_en   = 1'b1;
                    rd_addr = ring_pos(head_reg, CW'(in_offset));
                end
            end
            fwoh_pkg::REQ_CLEAR: begin
                head_next     = '0;
                count_next    = '0;
                dst_halt_next = 1'b0;
                if (src_halt_reg) begin
                    src_halt_next           = 1'b0;
                    res_next.source_release = 1'b1;
                end
            end
            default: ;
        endcase
        res_next.fill_level = 7'(count_next);
        res_next.peak_spill = 6'(peak_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            count_reg     <= '0;
            src_halt_reg  <= 1'b0;
            dst_halt_reg  <= 1'b0;
            peak_reg      <= '0;
            depth_reg     <= fwoh_pkg::DEPTH_RESET;
            res_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                depth_reg    <= cfg_data;
                head_reg     <= '0;
                count_reg    <= '0;
                src_halt_reg <= 1'b0;
                dst_halt_reg <= 1'b0;
            end else if (accept) begin
                head_reg     <= head_next;
                count_reg    <= count_next;
                src_halt_reg <= src_halt_next;
                dst_halt_reg <= dst_halt_next;
                peak_reg     <= peak_next;
            end
            if (accept) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // ring store with registered read, data lands beside the result register
    always_ff @(posedge aclk) begin
        if (accept && wr_en) begin
            ring_mem[wr_addr] <= in_word;
        end
        if (accept) begin
            res_reg     <= res_next;
            rd_word_reg <= rd_en ? ring_mem[rd_addr] : 32'd0;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= 32'(RING))
        else $error("fill count beyond ring size");

    a_src_halt_spill: assert property (@(posedge aclk) disable iff (!aresetn)
        src_halt_reg |-> (count_reg > depth_eff))
        else $error("source halted without overflow contents");

    a_dst_halt_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        dst_halt_reg |-> (count_reg == '0))
        else $error("destination halted while words are held");

    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !cfg_valid && in_req == fwoh_pkg::REQ_POP && count_reg == '0)
        |=> (res_valid && res.empty_retry && res.read_word == 32'd0))
        else $error("pop from empty did not report retry");
`endif

endmodule

// File: rtl/fwoh_skid.sv
// Two-entry output buffer so the engine keeps taking requests under stall.
// Depends on fwoh_pkg.
module fwoh_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  fwoh_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output fwoh_pkg::result_t out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    fwoh_pkg::result_t out_data_reg;
    fwoh_pkg::result_t skid_data_reg;
    logic              in_fire;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_fire;
            end
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_fire) begin
            skid_data_reg <= in_data;
        end
    end

`ifndef ASSERT_OFF
    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output slot empty");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> $stable(out_data))
        else $error("output word changed while stalled");
`endif

endmodule

// File: rtl/fifo_with_overflow_halt.sv
// Top level of the word FIFO with overflow halt.
// Depends on fwoh_pkg, fwoh_core and fwoh_skid.
//
// Usage:
//   s_ channel carries requests: s_tuser is the request kind (push, pop,
//   peek, clear), s_tdata the push word and peek offset.
//   m_ channel returns exactly one result word per request: the read word,
//   one-shot halt/release/retry/drop flags, the fill level and the peak
//   overflow level.
//   cfg channel writes the visible depth (1..32, 0 acts as 1); a write
//   empties the store and drops both halts, keeps the peak, and gives no
//   result. Write it only while no request is in flight. cfg_ready is
//   always high.
// Result path: the ring read lands in the engine result register and is
//   then moved into the output register of the skid buffer.
// Throughput: one request per cycle while s_tready is high; a stored push, a pop
//   from a non-empty store and a clear move the ring pointers as they are accepted.
// Stall: three results are buffered (engine result register, output
//   register and skid entry); s_tready drops once all three are held and
//   m_tready stays low.
// Reset: store empty, halts and peak zero, depth 32; no clearing pass is
//   needed because only entries below the fill level are ever read.
module fifo_with_overflow_halt #(
    parameter int MAX_VISIBLE = fwoh_pkg::MAX_VISIBLE_DEF,
    parameter int SPILL_DEPTH = fwoh_pkg::SPILL_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] push_word, [37:32] peek_offset, [39:38] zero
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [31:0] read_word, [32] source_halt,
                                   // [33] source_release, [34] empty_retry,
                                   // [35] dest_halt, [36] dest_release,
                                   // [37] push_dropped, [44:38] fill_level,
                                   // [50:45] peak_spill, [55:51] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data   // [5:0] visible_depth
);

    fwoh_pkg::result_t core_res;
    fwoh_pkg::result_t out_res;
    fwoh_pkg::req_t    req;
    logic              core_valid;
    logic              core_ready;

    // the depth register never pushes back
    assign cfg_ready = 1'b1;

    assign req = fwoh_pkg::req_t'(s_tuser);

    fwoh_core #(
        .MAX_VISIBLE (MAX_VISIBLE),
        .SPILL_DEPTH (SPILL_DEPTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (req),
        .in_word   (s_tdata[31:0]),
        .in_offset (s_tdata[37:32]),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .res_valid (core_valid),
        .res_ready (core_ready),
        .res       (core_res)
    );

    fwoh_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (core_valid),
        .in_ready  (core_ready),
        .in_data   (core_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // result struct is already laid out low field first
    assign m_tdata = {5'd0, out_res};

endmodule
